/* hdl/stq_pkg.sv */
// Shared types, constants and helper functions of the square-to-quad warp matrix block.
package stq_pkg;

    localparam int CW   = 32;
    localparam int DW   = CW + 1;
    localparam int PW   = CW + 2;
    localparam int DETW = 2 * DW + 1;
    localparam int NUMW = PW + DW + 1;
    localparam int RW   = NUMW;
    localparam int FRAC = 16;
    localparam int NW   = NUMW + FRAC;
    localparam int QW   = 32;
    localparam int SUMW = 2 * CW - FRAC + 1;

    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] x3;
        logic signed [CW-1:0] y3;
    } t_quad;

    typedef struct packed {
        t_quad                quad;
        logic signed [DW-1:0] dx1;
        logic signed [DW-1:0] dx2;
        logic signed [DW-1:0] dy1;
        logic signed [DW-1:0] dy2;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic                 affine;
    } t_front;

    typedef struct packed {
        t_quad quad;
        logic  affine;
        logic  zero;
        logic  neg_g;
        logic  neg_h;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] value;
        logic                 clipped;
    } t_sat;

    function automatic logic signed [DW-1:0] sx_d(input logic signed [CW-1:0] a);
        return {a[CW-1], a};
    endfunction

    function automatic logic signed [PW-1:0] sx_p(input logic signed [CW-1:0] a);
        return {{2{a[CW-1]}}, a};
    endfunction

    function automatic logic signed [SUMW-1:0] sx_s(input logic signed [CW-1:0] a);
        return {{(SUMW-CW){a[CW-1]}}, a};
    endfunction

    function automatic t_sat sat_q(input logic signed [SUMW-1:0] v);
        t_sat r;
        if (v[SUMW-1:CW-1] == '0 || v[SUMW-1:CW-1] == '1) begin
            r.value   = v[CW-1:0];
            r.clipped = 1'b0;
        end else begin
            r.value   = v[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            r.clipped = 1'b1;
        end
        return r;
    endfunction

endpackage

/* hdl/stq_front.sv */
// Front stage: takes an item, forms the corner differences and classifies it as affine or not.
module stq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  stq_pkg::t_quad       i_quad,
    input  logic                 i_full,
    output logic                 o_busy,
    output logic                 o_push,
    output stq_pkg::t_front      o_data
);

    logic            r_valid;
    logic            n_valid;
    logic            w_accept;
    stq_pkg::t_front r_data;
    stq_pkg::t_front n_data;

    assign o_busy   = r_valid && i_full;
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_valid && !i_full;
    assign o_data   = r_data;

    always_comb begin
        n_valid = w_accept ? 1'b1 : (o_push ? 1'b0 : r_valid);
        n_data.quad = i_quad;
        n_data.dx1  = stq_pkg::sx_d(i_quad.x1) - stq_pkg::sx_d(i_quad.x3);
        n_data.dx2  = stq_pkg::sx_d(i_quad.x2) - stq_pkg::sx_d(i_quad.x3);
        n_data.dy1  = stq_pkg::sx_d(i_quad.y1) - stq_pkg::sx_d(i_quad.y3);
        n_data.dy2  = stq_pkg::sx_d(i_quad.y2) - stq_pkg::sx_d(i_quad.y3);
        n_data.px   = stq_pkg::sx_p(i_quad.x0) - stq_pkg::sx_p(i_quad.x1)
                    + stq_pkg::sx_p(i_quad.x3) - stq_pkg::sx_p(i_quad.x2);
        n_data.py   = stq_pkg::sx_p(i_quad.y0) - stq_pkg::sx_p(i_quad.y1)
                    + stq_pkg::sx_p(i_quad.y3) - stq_pkg::sx_p(i_quad.y2);
        n_data.affine = (n_data.px == '0) && (n_data.py == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= n_data;
        end
    end

endmodule

/* hdl/stq_fifo.sv */
// Two-entry queue between the front and the back of the block.
module stq_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Item pushed into a full queue.");

endmodule

/* hdl/stq_divider.sv */
// Pipelined restoring divider that forms the quotients of g and h, one bit per stage.
module stq_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [stq_pkg::NW-1:0]     i_num_g,
    input  logic [stq_pkg::NW-1:0]     i_num_h,
    input  logic [stq_pkg::RW-1:0]     i_den,
    input  stq_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [stq_pkg::QW-1:0]     o_q_g,
    output logic [stq_pkg::QW-1:0]     o_q_h,
    output logic                       o_ovf_g,
    output logic                       o_ovf_h,
    output stq_pkg::t_side             o_side
);

    localparam int QW = stq_pkg::QW;
    localparam int RW = stq_pkg::RW;
    localparam int NW = stq_pkg::NW;
    localparam int XW = NW + QW - (NW - RW);

    typedef struct packed {
        logic [RW-1:0]  rem_g;
        logic [RW-1:0]  rem_h;
        logic [QW-1:0]  low_g;
        logic [QW-1:0]  low_h;
        logic [QW-1:0]  q_g;
        logic [QW-1:0]  q_h;
        logic [RW-1:0]  den;
        logic           ovf_g;
        logic           ovf_h;
        stq_pkg::t_side side;
    } t_dstage;

    function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic bit_in,
                                             input logic [RW-1:0] den);
        logic [RW-1:0] trial;
        trial = {rem[RW-2:0], bit_in};
        if (trial >= den) begin
            return {1'b1, trial - den};
        end
        return {1'b0, trial};
    endfunction

    t_dstage r_st  [QW+1];
    logic    r_vld [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0].rem_g <= RW'(i_num_g[NW-1:QW]);
        r_st[0].rem_h <= RW'(i_num_h[NW-1:QW]);
        r_st[0].low_g <= i_num_g[QW-1:0];
        r_st[0].low_h <= i_num_h[QW-1:0];
        r_st[0].q_g   <= '0;
        r_st[0].q_h   <= '0;
        r_st[0].den   <= i_den;
        r_st[0].ovf_g <= {(XW-NW)'(0), i_num_g} >= {i_den, QW'(0)};
        r_st[0].ovf_h <= {(XW-NW)'(0), i_num_h} >= {i_den, QW'(0)};
        r_st[0].side  <= i_side;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW:0] w_g;
        logic [RW:0] w_h;
        t_dstage     n_st;
        assign w_g = div_step(r_st[k].rem_g, r_st[k].low_g[QW-1-k], r_st[k].den);
        assign w_h = div_step(r_st[k].rem_h, r_st[k].low_h[QW-1-k], r_st[k].den);

        always_comb begin
            n_st       = r_st[k];
            n_st.rem_g = w_g[RW-1:0];
            n_st.rem_h = w_h[RW-1:0];
            n_st.q_g   = {r_st[k].q_g[QW-2:0], w_g[RW]};
            n_st.q_h   = {r_st[k].q_h[QW-2:0], w_h[RW]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[k+1] <= n_st;
        end
    end

    assign o_valid = r_vld[QW];
    assign o_q_g   = r_st[QW].q_g;
    assign o_q_h   = r_st[QW].q_h;
    assign o_ovf_g = r_st[QW].ovf_g;
    assign o_ovf_h = r_st[QW].ovf_h;
    assign o_side  = r_st[QW].side;

endmodule

/* hdl/stq_back.sv */
// Back part: determinant, perspective terms, products and the saturated matrix entries.
module stq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  stq_pkg::t_front               i_data,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic signed [stq_pkg::CW-1:0] o_coef [8],
    output logic                          o_saturated
);

    localparam int CW   = stq_pkg::CW;
    localparam int DW   = stq_pkg::DW;
    localparam int PW   = stq_pkg::PW;
    localparam int DETW = stq_pkg::DETW;
    localparam int NUMW = stq_pkg::NUMW;
    localparam int RW   = stq_pkg::RW;
    localparam int NW   = stq_pkg::NW;
    localparam int QW   = stq_pkg::QW;
    localparam int FRAC = stq_pkg::FRAC;
    localparam int SUMW = stq_pkg::SUMW;
    localparam int LAT  = 3 + QW + 1 + 3;

    // Products of the corner differences.
    logic                      r_v0;
    logic signed [2*DW-1:0]    r_pa;
    logic signed [2*DW-1:0]    r_pb;
    logic signed [PW+DW-1:0]   r_pc;
    logic signed [PW+DW-1:0]   r_pd;
    logic signed [PW+DW-1:0]   r_pe;
    logic signed [PW+DW-1:0]   r_pf;
    stq_pkg::t_quad            r_q0;
    logic                      r_a0;

    always_ff @(posedge i_clk) begin
        r_pa <= $signed(i_data.dx1) * $signed(i_data.dy2);
        r_pb <= $signed(i_data.dx2) * $signed(i_data.dy1);
        r_pc <= $signed(i_data.px) * $signed(i_data.dy2);
        r_pd <= $signed(i_data.dx2) * $signed(i_data.py);
        r_pe <= $signed(i_data.dx1) * $signed(i_data.py);
        r_pf <= $signed(i_data.px) * $signed(i_data.dy1);
        r_q0 <= i_data.quad;
        r_a0 <= i_data.affine;
    end

    // Determinant and numerators.
    logic                      r_v1;
    logic signed [DETW-1:0]    r_det;
    logic signed [NUMW-1:0]    r_ng;
    logic signed [NUMW-1:0]    r_nh;
    stq_pkg::t_quad            r_q1;
    logic                      r_a1;

    always_ff @(posedge i_clk) begin
        r_det <= {r_pa[2*DW-1], r_pa} - {r_pb[2*DW-1], r_pb};
        r_ng  <= {r_pc[PW+DW-1], r_pc} - {r_pd[PW+DW-1], r_pd};
        r_nh  <= {r_pe[PW+DW-1], r_pe} - {r_pf[PW+DW-1], r_pf};
        r_q1  <= r_q0;
        r_a1  <= r_a0;
    end

    // Magnitudes and signs for the divider.
    logic                      r_v2;
    logic [NW-1:0]             r_num_g;
    logic [NW-1:0]             r_num_h;
    logic [RW-1:0]             r_den;
    stq_pkg::t_side            r_side2;
    logic [RW-1:0]             w_det_ext;

    assign w_det_ext = RW'({{(RW-DETW){r_det[DETW-1]}}, r_det});

    always_ff @(posedge i_clk) begin
        r_den   <= r_det[DETW-1] ? RW'(0) - w_det_ext : w_det_ext;
        r_num_g <= {(r_ng[NUMW-1] ? NUMW'(0) - r_ng : r_ng), FRAC'(0)};
        r_num_h <= {(r_nh[NUMW-1] ? NUMW'(0) - r_nh : r_nh), FRAC'(0)};
        r_side2.quad   <= r_q1;
        r_side2.affine <= r_a1;
        r_side2.zero   <= (r_det == '0);
        r_side2.neg_g  <= r_ng[NUMW-1] ^ r_det[DETW-1];
        r_side2.neg_h  <= r_nh[NUMW-1] ^ r_det[DETW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    logic                      w_dv;
    logic [QW-1:0]             w_qg;
    logic [QW-1:0]             w_qh;
    logic                      w_og;
    logic                      w_oh;
    stq_pkg::t_side            w_ds;

    stq_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_num_g (r_num_g),
        .i_num_h (r_num_h),
        .i_den   (r_den),
        .i_side  (r_side2),
        .o_valid (w_dv),
        .o_q_g   (w_qg),
        .o_q_h   (w_qh),
        .o_ovf_g (w_og),
        .o_ovf_h (w_oh),
        .o_side  (w_ds)
    );

    // Signed, saturated g and h.
    logic                      r_v3;
    logic signed [CW-1:0]      r_g;
    logic signed [CW-1:0]      r_h;
    logic                      r_sgh;
    stq_pkg::t_side            r_side3;
    logic                      w_cg;
    logic                      w_ch;
    logic                      w_proj;

    assign w_cg   = w_og || (w_ds.neg_g ? (w_qg > {1'b1, (QW-1)'(0)}) : w_qg[QW-1]);
    assign w_ch   = w_oh || (w_ds.neg_h ? (w_qh > {1'b1, (QW-1)'(0)}) : w_qh[QW-1]);
    assign w_proj = !w_ds.zero && !w_ds.affine;

    always_ff @(posedge i_clk) begin
        if (w_cg) begin
            r_g <= w_ds.neg_g ? {1'b1, (CW-1)'(0)} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            r_g <= w_ds.neg_g ? CW'(0) - w_qg : w_qg;
        end
        if (w_ch) begin
            r_h <= w_ds.neg_h ? {1'b1, (CW-1)'(0)} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            r_h <= w_ds.neg_h ? CW'(0) - w_qh : w_qh;
        end
        r_sgh   <= w_proj && (w_cg || w_ch);
        r_side3 <= w_ds;
    end

    // Perspective products.
    logic                      r_v4;
    logic signed [2*CW-1:0]    r_gx1;
    logic signed [2*CW-1:0]    r_gy1;
    logic signed [2*CW-1:0]    r_hx2;
    logic signed [2*CW-1:0]    r_hy2;
    logic signed [CW-1:0]      r_g4;
    logic signed [CW-1:0]      r_h4;
    logic                      r_sgh4;
    stq_pkg::t_side            r_side4;

    always_ff @(posedge i_clk) begin
        r_gx1   <= r_g * r_side3.quad.x1;
        r_gy1   <= r_g * r_side3.quad.y1;
        r_hx2   <= r_h * r_side3.quad.x2;
        r_hy2   <= r_h * r_side3.quad.y2;
        r_g4    <= r_g;
        r_h4    <= r_h;
        r_sgh4  <= r_sgh;
        r_side4 <= r_side3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= w_dv;
            r_v4 <= r_v3;
        end
    end

    // Final sums and output register.
    logic                      r_strobe;
    logic                      r_status;
    logic signed [CW-1:0]      r_coef [8];
    logic                      r_sat;
    logic                      n_status;
    logic signed [CW-1:0]      n_coef [8];
    logic                      n_sat;
    stq_pkg::t_sat             w_s0;
    stq_pkg::t_sat             w_s1;
    stq_pkg::t_sat             w_s3;
    stq_pkg::t_sat             w_s4;
    stq_pkg::t_quad            w_q;

    function automatic logic signed [SUMW-1:0] scale(input logic signed [2*CW-1:0] p);
        return {p[2*CW-1], p[2*CW-1:FRAC]};
    endfunction

    assign w_q = r_side4.quad;

    always_comb begin
        if (r_side4.affine) begin
            w_s0 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.x1) - stq_pkg::sx_s(w_q.x0));
            w_s1 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.y1) - stq_pkg::sx_s(w_q.y0));
            w_s3 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.x3) - stq_pkg::sx_s(w_q.x1));
            w_s4 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.y3) - stq_pkg::sx_s(w_q.y1));
        end else begin
            w_s0 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.x1) - stq_pkg::sx_s(w_q.x0) + scale(r_gx1));
            w_s1 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.y1) - stq_pkg::sx_s(w_q.y0) + scale(r_gy1));
            w_s3 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.x2) - stq_pkg::sx_s(w_q.x0) + scale(r_hx2));
            w_s4 = stq_pkg::sat_q(stq_pkg::sx_s(w_q.y2) - stq_pkg::sx_s(w_q.y0) + scale(r_hy2));
        end
        n_status  = r_side4.zero;
        n_coef[0] = w_s0.value;
        n_coef[1] = w_s1.value;
        n_coef[2] = r_side4.affine ? CW'(0) : r_g4;
        n_coef[3] = w_s3.value;
        n_coef[4] = w_s4.value;
        n_coef[5] = r_side4.affine ? CW'(0) : r_h4;
        n_coef[6] = w_q.x0;
        n_coef[7] = w_q.y0;
        n_sat     = r_sgh4 || w_s0.clipped || w_s1.clipped || w_s3.clipped || w_s4.clipped;
        if (r_side4.zero) begin
            for (int i = 0; i < 8; i++) begin
                n_coef[i] = '0;
            end
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_coef   <= n_coef;
        r_sat    <= n_sat;
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_coef      = r_coef;
    assign o_saturated = r_sat;

    item_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##LAT o_strobe)
        else $error("Item did not reach the output after the pipeline latency.");

    bad_warp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (!o_saturated && o_coef[2] == '0 && o_coef[6] == '0))
        else $error("Bad warp result carries nonzero fields.");

endmodule

/* hdl/square_to_quad_warp_matrix_top.sv */
// Top level of the square-to-quad warp matrix block.
//
//  Channel   Handshake              Fields
//  input     i_start / o_busy       i_corner0_x .. i_corner3_y (signed Q16.16)
//  result    o_strobe (one cycle)   o_status, o_coef_0 .. o_coef_7, o_saturated
//
// One item is accepted per cycle; results appear in the order in which their items were taken.
// The rate is set by the 32-stage restoring divider, which takes a new item every cycle.
// Reset is synchronous and clears all valid flags; in-flight items are dropped.
// The results cannot be held off, so the back part never stalls and o_busy stays low.
module square_to_quad_warp_matrix_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_corner0_x,
    input  logic [31:0] i_corner0_y,
    input  logic [31:0] i_corner1_x,
    input  logic [31:0] i_corner1_y,
    input  logic [31:0] i_corner2_x,
    input  logic [31:0] i_corner2_y,
    input  logic [31:0] i_corner3_x,
    input  logic [31:0] i_corner3_y,
    output logic        o_strobe,
    output logic        o_status,
    output logic [31:0] o_coef_0,
    output logic [31:0] o_coef_1,
    output logic [31:0] o_coef_2,
    output logic [31:0] o_coef_3,
    output logic [31:0] o_coef_4,
    output logic [31:0] o_coef_5,
    output logic [31:0] o_coef_6,
    output logic [31:0] o_coef_7,
    output logic        o_saturated
);

    stq_pkg::t_quad               w_quad;
    stq_pkg::t_front              w_fdata;
    logic                         w_push;
    logic                         w_full;
    logic                         w_qvalid;
    logic [$bits(stq_pkg::t_front)-1:0] w_qdata;
    logic signed [stq_pkg::CW-1:0] w_coef [8];

    assign w_quad.x0 = i_corner0_x;
    assign w_quad.y0 = i_corner0_y;
    assign w_quad.x1 = i_corner1_x;
    assign w_quad.y1 = i_corner1_y;
    assign w_quad.x2 = i_corner2_x;
    assign w_quad.y2 = i_corner2_y;
    assign w_quad.x3 = i_corner3_x;
    assign w_quad.y3 = i_corner3_y;

    stq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_quad  (w_quad),
        .i_full  (w_full),
        .o_busy  (o_busy),
        .o_push  (w_push),
        .o_data  (w_fdata)
    );

    stq_fifo #(
        .W ($bits(stq_pkg::t_front))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fdata),
        .i_pop   (w_qvalid),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_data  (w_qdata)
    );

    stq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qvalid),
        .i_data      (stq_pkg::t_front'(w_qdata)),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_coef      (w_coef),
        .o_saturated (o_saturated)
    );

    assign o_coef_0 = w_coef[0];
    assign o_coef_1 = w_coef[1];
    assign o_coef_2 = w_coef[2];
    assign o_coef_3 = w_coef[3];
    assign o_coef_4 = w_coef[4];
    assign o_coef_5 = w_coef[5];
    assign o_coef_6 = w_coef[6];
    assign o_coef_7 = w_coef[7];

endmodule

/* dv/square_to_quad_warp_matrix_checker.sv */
// Checker for the square-to-quad warp matrix block: predicts each result and compares it.
module square_to_quad_warp_matrix_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_corner0_x,
    input  logic [31:0] i_corner0_y,
    input  logic [31:0] i_corner1_x,
    input  logic [31:0] i_corner1_y,
    input  logic [31:0] i_corner2_x,
    input  logic [31:0] i_corner2_y,
    input  logic [31:0] i_corner3_x,
    input  logic [31:0] i_corner3_y,
    input  logic        i_strobe,
    input  logic        i_status,
    input  logic [31:0] i_coef_0,
    input  logic [31:0] i_coef_1,
    input  logic [31:0] i_coef_2,
    input  logic [31:0] i_coef_3,
    input  logic [31:0] i_coef_4,
    input  logic [31:0] i_coef_5,
    input  logic [31:0] i_coef_6,
    input  logic [31:0] i_coef_7,
    input  logic        i_saturated,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_matrix_count,
    output int          o_bad_count,
    output int          o_sat_count
);

    typedef struct {
        logic        status;
        logic [31:0] coef [8];
        logic        saturated;
    } t_warp;

    t_warp warp_queue [$];

    function automatic logic [31:0] clip_q16(input logic signed [127:0] v, inout logic flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fffffff;
        end else if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_warp warp_matrix(input stq_pkg::t_quad q);
        logic signed [127:0] x0, y0, x1, y1, x2, y2, x3, y3;
        logic signed [127:0] dx1, dx2, dy1, dy2, px, py, det, g, h;
        t_warp r;
        logic clip;
        x0 = q.x0; y0 = q.y0; x1 = q.x1; y1 = q.y1;
        x2 = q.x2; y2 = q.y2; x3 = q.x3; y3 = q.y3;
        clip = 1'b0;
        r.status = 1'b0;
        for (int i = 0; i < 8; i++) r.coef[i] = '0;
        dx1 = x1 - x3; dx2 = x2 - x3; dy1 = y1 - y3; dy2 = y2 - y3;
        px = x0 - x1 + x3 - x2;
        py = y0 - y1 + y3 - y2;
        det = dx1 * dy2 - dx2 * dy1;
        if (det == 0) begin
            r.status = 1'b1;
        end else if (px == 0 && py == 0) begin
            r.coef[0] = clip_q16(x1 - x0, clip);
            r.coef[1] = clip_q16(y1 - y0, clip);
            r.coef[3] = clip_q16(x3 - x1, clip);
            r.coef[4] = clip_q16(y3 - y1, clip);
            r.coef[6] = q.x0;
            r.coef[7] = q.y0;
        end else begin
            g = ((px * dy2 - dx2 * py) <<< 16) / det;
            h = ((dx1 * py - px * dy1) <<< 16) / det;
            r.coef[2] = clip_q16(g, clip);
            r.coef[5] = clip_q16(h, clip);
            g = $signed(r.coef[2]);
            h = $signed(r.coef[5]);
            r.coef[0] = clip_q16(x1 - x0 + ((g * x1) >>> 16), clip);
            r.coef[1] = clip_q16(y1 - y0 + ((g * y1) >>> 16), clip);
            r.coef[3] = clip_q16(x2 - x0 + ((h * x2) >>> 16), clip);
            r.coef[4] = clip_q16(y2 - y0 + ((h * y2) >>> 16), clip);
            r.coef[6] = q.x0;
            r.coef[7] = q.y0;
        end
        r.saturated = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h (matrix %0d)",
                 $realtime, what, got, want, o_matrix_count);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_matrix_count = 0;
        o_bad_count    = 0;
        o_sat_count    = 0;
    end

    assign o_pending = warp_queue.size();

    always @(posedge i_clk) begin
        stq_pkg::t_quad q;
        t_warp want;
        logic [31:0] got [8];
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                q.x0 = i_corner0_x; q.y0 = i_corner0_y;
                q.x1 = i_corner1_x; q.y1 = i_corner1_y;
                q.x2 = i_corner2_x; q.y2 = i_corner2_y;
                q.x3 = i_corner3_x; q.y3 = i_corner3_y;
                warp_queue.push_back(warp_matrix(q));
            end
            if (i_strobe) begin
                if (warp_queue.size() == 0) begin
                    report_mismatch("unexpected result", {31'b0, i_status}, '0);
                end else begin
                    want = warp_queue.pop_front();
                    got = '{i_coef_0, i_coef_1, i_coef_2, i_coef_3,
                            i_coef_4, i_coef_5, i_coef_6, i_coef_7};
                    if (i_status !== want.status)
                        report_mismatch("status", {31'b0, i_status}, {31'b0, want.status});
                    for (int i = 0; i < 8; i++)
                        if (got[i] !== want.coef[i])
                            report_mismatch($sformatf("coef_%0d", i), got[i], want.coef[i]);
                    if (i_saturated !== want.saturated)
                        report_mismatch("saturated", {31'b0, i_saturated},
                                        {31'b0, want.saturated});
                    if (want.status) o_bad_count++;
                    if (want.saturated) o_sat_count++;
                end
                o_matrix_count++;
            end
        end
    end

endmodule

/* dv/square_to_quad_warp_matrix_top_tb.sv */
// Testbench top for the square-to-quad warp matrix block: stimulus and verdict.
module square_to_quad_warp_matrix_top_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_corner0_x, i_corner0_y, i_corner1_x, i_corner1_y;
    logic [31:0] i_corner2_x, i_corner2_y, i_corner3_x, i_corner3_y;
    logic        o_strobe, o_status, o_saturated;
    logic [31:0] o_coef_0, o_coef_1, o_coef_2, o_coef_3;
    logic [31:0] o_coef_4, o_coef_5, o_coef_6, o_coef_7;
    logic        busy_seen;
    int          fail_count, pending, matrix_count, bad_count, sat_count;
    int          quad_count;

    square_to_quad_warp_matrix_top dut (.*);

    square_to_quad_warp_matrix_checker checker_inst (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_corner0_x, .i_corner0_y, .i_corner1_x, .i_corner1_y,
        .i_corner2_x, .i_corner2_y, .i_corner3_x, .i_corner3_y,
        .i_strobe(o_strobe), .i_status(o_status),
        .i_coef_0(o_coef_0), .i_coef_1(o_coef_1), .i_coef_2(o_coef_2),
        .i_coef_3(o_coef_3), .i_coef_4(o_coef_4), .i_coef_5(o_coef_5),
        .i_coef_6(o_coef_6), .i_coef_7(o_coef_7), .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_matrix_count(matrix_count), .o_bad_count(bad_count),
        .o_sat_count(sat_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The busy flag only moves at rising edges, so its value here holds at the next edge.
    always @(negedge i_clk) busy_seen <= o_busy;

    initial begin
        #2000000;
        $display("Timeout after %0d quads.", quad_count);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] near(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic stq_pkg::t_quad random_quad();
        stq_pkg::t_quad q;
        int kind;
        logic [31:0] ux, uy;
        int k, m;
        kind = $urandom_range(0, 9);
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind <= 3) begin
            q.x0 = near(32'h8000);   q.y0 = near(32'h8000);
            q.x1 = 32'h10000 + near(32'h8000); q.y1 = near(32'h8000);
            q.x2 = near(32'h8000);   q.y2 = 32'h10000 + near(32'h8000);
            q.x3 = 32'h10000 + near(32'h8000); q.y3 = 32'h10000 + near(32'h8000);
            if (kind == 0) begin
                q.x0 = near(1 << 26); q.y0 = near(1 << 26);
                q.x1 = near(1 << 26); q.y1 = near(1 << 26);
            end
        end else if (kind <= 5) begin
            q.x0 = near(1 << 24); q.y0 = near(1 << 24);
            q.x1 = near(1 << 24); q.y1 = near(1 << 24);
            q.x2 = near(1 << 24); q.y2 = near(1 << 24);
            if (kind == 5) begin
                q.x0 = $urandom; q.x1 = $urandom; q.y2 = $urandom;
            end
            q.x3 = q.x1 + q.x2 - q.x0;
            q.y3 = q.y1 + q.y2 - q.y0;
        end else if (kind == 6) begin
            ux = near(1 << 12); uy = near(1 << 12);
            k = $urandom_range(0, 7) - 3; m = $urandom_range(0, 7) - 3;
            q.x1 = q.x3 + 32'(k) * ux; q.y1 = q.y3 + 32'(k) * uy;
            q.x2 = q.x3 + 32'(m) * ux; q.y2 = q.y3 + 32'(m) * uy;
        end else if (kind == 7) begin
            q.x0 = near(1 << 30); q.y0 = near(1 << 30);
            q.x1 = near(1 << 30); q.y1 = near(1 << 30);
            q.x2 = near(1 << 30); q.y2 = near(1 << 30);
            q.x3 = near(1 << 30); q.y3 = near(1 << 30);
        end
        return q;
    endfunction

    task automatic send_quad(input stq_pkg::t_quad q, input int gap);
        i_start     <= 1'b1;
        i_corner0_x <= q.x0; i_corner0_y <= q.y0;
        i_corner1_x <= q.x1; i_corner1_y <= q.y1;
        i_corner2_x <= q.x2; i_corner2_y <= q.y2;
        i_corner3_x <= q.x3; i_corner3_y <= q.y3;
        do @(posedge i_clk); while (busy_seen);
        quad_count++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        stq_pkg::t_quad directed [$];
        stq_pkg::t_quad q;
        int quiet;
        quad_count  = 0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_corner0_x = '0; i_corner0_y = '0; i_corner1_x = '0; i_corner1_y = '0;
        i_corner2_x = '0; i_corner2_y = '0; i_corner3_x = '0; i_corner3_y = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner order: (0,0), (1,0), (0,1), (1,1).
        directed.push_back('0);
        directed.push_back({32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000,
                            32'h10000, 32'h10000});
        directed.push_back({32'h0, 32'h0, 32'h20000, 32'h0, 32'h0, 32'h10000,
                            32'h18000, 32'h10000});
        directed.push_back({32'h10000, 32'h0, 32'h30000, 32'h8000, 32'h0, 32'h20000,
                            32'h28000, 32'h30000});
        directed.push_back({8{32'h7fffffff}});
        directed.push_back({8{32'h80000000}});
        directed.push_back({32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        directed.push_back({32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000});
        directed.push_back({32'h80000000, 32'h0, 32'h7fffffff, 32'h0, 32'h80000000,
                            32'h1, 32'h7fffffff, 32'h1});
        directed.push_back({32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1});
        directed.push_back({32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3});
        directed.push_back({32'h12345, 32'h0, 32'h10000, 32'h10000, 32'h20000,
                            32'h20000, 32'h30000, 32'h30000});
        directed.push_back({32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1,
                            32'h1, 32'h1});
        directed.push_back({32'hffff0000, 32'hffff0000, 32'h10000, 32'hffff0000,
                            32'hffff0000, 32'h10000, 32'h8000, 32'h8000});
        directed.push_back({32'h0, 32'h0, 32'h7fff0000, 32'h0, 32'h0, 32'h7fff0000,
                            32'h1, 32'h1});
        directed.push_back({32'hffffffff, 32'hffffffff, 32'h0, 32'hffffffff,
                            32'hffffffff, 32'h0, 32'h0, 32'h0});
        directed.push_back({32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                            32'h33333333, 32'hcccccccc, 32'hcccccccc, 32'h33333333});
        foreach (directed[i]) send_quad(directed[i], i % 3);

        for (int n = 0; n < 1400; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (n == 700) begin
                i_start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            q = random_quad();
            send_quad(q, quiet ? 0 : $urandom_range(0, 14));
        end
        i_start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d quads, checked %0d matrices.", quad_count, matrix_count);
        $display("Degenerate warps: %0d, saturated matrices: %0d.", bad_count, sat_count);
        if (fail_count == 0 && matrix_count == quad_count) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/stq_pkg.sv
hdl/stq_front.sv
hdl/stq_fifo.sv
hdl/stq_divider.sv
hdl/stq_back.sv
hdl/square_to_quad_warp_matrix_top.sv
dv/square_to_quad_warp_matrix_checker.sv
dv/square_to_quad_warp_matrix_top_tb.sv
